// File: hdl/blmf_pkg.sv
// Shared types and constants for the battery level mode filter.
`default_nettype none

package blmf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LVL_W    = 7;
    localparam int SLOPE_W  = 8;

    // Conversion pipeline latency from sample register to level register
    localparam int CONV_LAT = 6;

    localparam logic [15:0] RECIP10   = 16'd52429;
    localparam logic [15:0] TEN       = 16'd10;
    localparam logic [27:0] MV_SCALE  = 28'd3350;
    localparam logic [12:0] MV_HIGH   = 13'd4200;
    localparam logic [12:0] MV_LOW    = 13'd3000;
    localparam logic [21:0] RECIP12   = 22'd2731;
    localparam logic [14:0] RECIP5    = 15'd205;
    localparam logic [LVL_W-1:0] LVL_STEP = 7'd5;
    localparam logic [LVL_W-1:0] LVL_MIN  = 7'd5;
    localparam logic [LVL_W-1:0] LVL_MAX  = 7'd100;

    typedef struct packed {
        logic load_sample;
        logic win_update;
        logic scan_start;
        logic scan_step;
        logic num_calc;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic div_last;
        logic short_win;
    } status_t;

endpackage

`default_nettype wire

// File: hdl/blmf_ctrl.sv
// Sequencer for the battery level mode filter: handshakes and step control.
`default_nettype none

module blmf_ctrl
    import blmf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cmd_t         cmd,
    input  wire status_t stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_NUM  = 3'd4;
    localparam logic [2:0] S_DIFF = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam int CC_W = $clog2(CONV_LAT);

    logic [2:0]      state_reg, state_next;
    logic [CC_W-1:0] conv_cnt_reg, conv_cnt_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        conv_cnt_next  = conv_cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    conv_cnt_next   = '0;
                    state_next      = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_cnt_reg == CC_W'(CONV_LAT - 1))
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    conv_cnt_next = conv_cnt_reg + 1'b1;
                end
            end
            S_UPD:
            begin
                cmd.win_update = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = stat.short_win ? S_OUT : S_NUM;
                end
            end
            S_NUM:
            begin
                cmd.num_calc = 1'b1;
                state_next   = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            conv_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conv_cnt_reg  <= conv_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before its item was taken");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sample |=> state_reg == S_CONV)
        else $error("sample load did not start conversion");

    a_div_after_num: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> $past(cmd.num_calc))
        else $error("divider started without products");

endmodule

`default_nettype wire

// File: hdl/blmf_datapath.sv
// Datapath: level conversion, history window, mode scan, slope and divider.
`default_nettype none

module blmf_datapath
    import blmf_pkg::*;
#(
    parameter int WINDOW_DEPTH = 5
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [SAMPLE_W-1:0]  adc_sample,
    input  wire logic                 flush,
    input  wire cmd_t                 cmd,
    output status_t                   stat,
    output logic [LVL_W-1:0]          level,
    output logic signed [SLOPE_W-1:0] slope
);

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int SY_W   = LVL_W + CNT_W;
    localparam int SXY_W  = LVL_W + 2 * CNT_W;
    localparam int SX_W   = 2 * CNT_W;
    localparam int SX2_W  = 3 * CNT_W;
    localparam int PROD_W = LVL_W + 4 * CNT_W;
    localparam int DC_W   = $clog2(PROD_W + 1);

    // Conversion pipeline
    logic [SAMPLE_W-1:0] sample_reg;
    logic                flush_reg;
    logic [31:0]         prod1_reg;
    logic [15:0]         raw10_reg;
    logic [27:0]         prod2_reg;
    logic [21:0]         q12_reg;
    logic [14:0]         pct5_reg;
    logic [LVL_W-1:0]    level_reg;
    logic [12:0]         mv;
    logic [12:0]         mv_clamp;
    logic [10:0]         dmv;
    logic [6:0]          pct_raw;
    logic [6:0]          pct;

    always_comb
    begin
        mv = {prod2_reg[27:16], 1'b0};
        if (mv > MV_HIGH)
        begin
            mv_clamp = MV_HIGH;
        end
        else if (mv < MV_LOW)
        begin
            mv_clamp = MV_LOW;
        end
        else
        begin
            mv_clamp = mv;
        end
        dmv     = 11'(mv_clamp - MV_LOW);
        pct_raw = q12_reg[21:15];
        pct     = (pct_raw == 7'd0) ? 7'd0 : pct_raw - 7'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= adc_sample;
            flush_reg  <= flush;
        end
        prod1_reg <= 32'(sample_reg) * 32'(RECIP10);
        raw10_reg <= 16'(prod1_reg[31:19]) * TEN;
        prod2_reg <= 28'(raw10_reg) * MV_SCALE;
        q12_reg   <= 22'(dmv) * RECIP12;
        pct5_reg  <= 15'(pct) * RECIP5;
        level_reg <= 7'(pct5_reg[14:10]) * LVL_STEP + LVL_MIN;
    end

    // History window
    logic [LVL_W-1:0] win_reg  [WINDOW_DEPTH];
    logic [LVL_W-1:0] win_next [WINDOW_DEPTH];
    logic [CNT_W-1:0] fill_reg, fill_next;

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (cmd.win_update)
        begin
            if (flush_reg)
            begin
                for (int i = 0; i < WINDOW_DEPTH; i++)
                begin
                    win_next[i] = level_reg;
                end
                fill_next = CNT_W'(WINDOW_DEPTH);
            end
            else if (fill_reg == CNT_W'(WINDOW_DEPTH))
            begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[WINDOW_DEPTH - 1] = level_reg;
            end
            else
            begin
                win_next[fill_reg[IDX_W-1:0]] = level_reg;
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
            fill_reg <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
        end
    end

    // Mode scan and slope sums, one entry per cycle
    logic [IDX_W-1:0] scan_idx_reg;
    logic [CNT_W-1:0] best_cnt_reg;
    logic [LVL_W-1:0] best_val_reg;
    logic [SY_W-1:0]  sumy_reg;
    logic [SXY_W-1:0] sumxy_reg;
    logic [SX_W-1:0]  sumx_reg;
    logic [SX2_W-1:0] sumx2_reg;
    logic [LVL_W-1:0] wk;
    logic [CNT_W-1:0] match_cnt;
    logic [CNT_W-1:0] pos;

    always_comb
    begin
        wk        = win_reg[scan_idx_reg];
        pos       = CNT_W'(scan_idx_reg) + 1'b1;
        match_cnt = '0;
        for (int j = 0; j < WINDOW_DEPTH; j++)
        begin
            if ((CNT_W'(j) > CNT_W'(scan_idx_reg)) && (CNT_W'(j) < fill_reg)
                && (win_reg[j] == wk))
            begin
                match_cnt = match_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
            best_cnt_reg <= '0;
            sumy_reg     <= '0;
            sumxy_reg    <= '0;
            sumx_reg     <= '0;
            sumx2_reg    <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if ((scan_idx_reg == '0) || (match_cnt > best_cnt_reg))
            begin
                best_cnt_reg <= match_cnt;
                best_val_reg <= wk;
            end
            sumy_reg  <= sumy_reg + SY_W'(wk);
            sumxy_reg <= sumxy_reg + SXY_W'(pos) * SXY_W'(wk);
            sumx_reg  <= sumx_reg + SX_W'(pos);
            sumx2_reg <= sumx2_reg + SX2_W'(pos) * SX2_W'(pos);
        end
    end

    // Slope numerator and denominator, then restoring division
    logic [PROD_W-1:0] nsxy_reg, sxsy_reg, nsx2_reg, sxsx_reg;
    logic [PROD_W:0]   num_diff;
    logic              num_neg;
    logic [PROD_W-1:0] num_mag;
    logic [PROD_W-1:0] rem_reg, quo_reg, den_reg;
    logic              neg_reg;
    logic [DC_W-1:0]   div_cnt_reg;
    logic [PROD_W:0]   shifted;
    logic [PROD_W+1:0] trial;
    logic [SLOPE_W-1:0] quo_low;

    always_comb
    begin
        num_diff = {1'b0, nsxy_reg} - {1'b0, sxsy_reg};
        num_neg  = num_diff[PROD_W];
        num_mag  = num_neg ? PROD_W'(-num_diff) : num_diff[PROD_W-1:0];
        shifted  = {rem_reg, quo_reg[PROD_W-1]};
        trial    = {1'b0, shifted} - {2'b00, den_reg};
        quo_low  = quo_reg[SLOPE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.num_calc)
        begin
            nsxy_reg <= PROD_W'(fill_reg) * PROD_W'(sumxy_reg);
            sxsy_reg <= PROD_W'(sumx_reg) * PROD_W'(sumy_reg);
            nsx2_reg <= PROD_W'(fill_reg) * PROD_W'(sumx2_reg);
            sxsx_reg <= PROD_W'(sumx_reg) * PROD_W'(sumx_reg);
        end
        if (cmd.div_start)
        begin
            rem_reg     <= '0;
            quo_reg     <= num_mag;
            den_reg     <= nsx2_reg - sxsx_reg;
            neg_reg     <= num_neg;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (!trial[PROD_W+1])
            begin
                rem_reg <= trial[PROD_W-1:0];
            end
            else
            begin
                rem_reg <= shifted[PROD_W-1:0];
            end
            quo_reg <= {quo_reg[PROD_W-2:0], ~trial[PROD_W+1]};
        end
    end

    // Result register
    logic [LVL_W-1:0]          level_out_reg;
    logic signed [SLOPE_W-1:0] slope_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            level_out_reg <= best_val_reg;
            if (stat.short_win)
            begin
                slope_out_reg <= '0;
            end
            else
            begin
                slope_out_reg <= neg_reg ? SLOPE_W'(-quo_low) : quo_low;
            end
        end
    end

    assign level = level_out_reg;
    assign slope = slope_out_reg;

    assign stat.scan_last = (pos == fill_reg);
    assign stat.div_last  = (div_cnt_reg == DC_W'(PROD_W - 1));
    assign stat.short_win = (fill_reg < CNT_W'(2));

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_flush_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.win_update && flush_reg) |=> fill_reg == CNT_W'(WINDOW_DEPTH))
        else $error("flush did not fill the window");

    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (CNT_W'(scan_idx_reg) < fill_reg))
        else $error("scan past filled entries");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.win_update |-> (level_reg >= LVL_MIN && level_reg <= LVL_MAX))
        else $error("converted level out of range");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> den_reg != '0)
        else $error("slope denominator is zero");

endmodule

`default_nettype wire

// File: hdl/battery_level_mode_filter_unit.sv
// Top level of the battery level mode filter: sequencer plus datapath.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------
//  input    | in_valid / in_ready  | adc_sample[15:0], flush
//  output   | out_valid / out_ready| level[6:0], slope[7:0] (signed)
//
// One item at a time, accepted only while idle. The scan visits the n filled window
// entries; the divider runs P = 7 + 4*clog2(WINDOW_DEPTH+1) steps (19 at depth 5).
// With fewer than two entries the divider is skipped.
// The restoring slope divider produces one quotient bit per cycle.
// Reset clears the window and fill count; no clearing pass is needed.
// The next item is taken while a finished result waits in the output register.
`default_nettype none

module battery_level_mode_filter_unit
    import blmf_pkg::*;
#(
    parameter int WINDOW_DEPTH = 5
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [SAMPLE_W-1:0]  adc_sample,
    input  wire logic                 flush,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [LVL_W-1:0]          level,
    output logic signed [SLOPE_W-1:0] slope
);

    cmd_t    cmd;
    status_t stat;

    blmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    blmf_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .adc_sample (adc_sample),
        .flush      (flush),
        .cmd        (cmd),
        .stat       (stat),
        .level      (level),
        .slope      (slope)
    );

endmodule

`default_nettype wire
